### hw/rtl/uri_path_component_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// URI path decoder assertion macros
// Clocked assertion wrappers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef URI_PATH_COMPONENT_DECODER_UNIT_DEFINES_SVH
`define URI_PATH_COMPONENT_DECODER_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define UPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define UPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// URI path decoder package
// Word types, result kinds and character constants for the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0]  ChPercent = 8'h25;
  localparam logic [7:0]  ChSlash   = 8'h2F;
  localparam logic [11:0] LenMax    = 12'hFFF;

  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindCompEnd = 2'd1,
    KindNameEnd = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [5:0]  comp_index;
    logic [11:0] comp_length;
    logic [5:0]  comp_total;
    logic        run_last;
  } result_word_t;

  // Case-blind hex digit; anything else reads as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
    logic [3:0] val;
    val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      val = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      val = 4'(ch - 8'h41 + 8'h0A);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      val = 4'(ch - 8'h61 + 8'h0A);
    end
    return val;
  endfunction

endpackage

### hw/rtl/upd_stream_if.sv
// ----------------------------------------------------------------------------
// URI path decoder stream interface
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface upd_stream_if #(
  parameter type word_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/uri_path_component_decoder_unit.sv
// ----------------------------------------------------------------------------
// URI path component decoder
// Splits a URI name into components and percent-decodes each one.
// ----------------------------------------------------------------------------
//
//  channel    dir  word            meaning
//  ---------  ---  --------------  -------------------------------------------
//  char_i     in   char_word_t     one URI character, flag on the last one
//  result_o   out  result_word_t   data byte, component end or name end
//
//  Cycles: a character is decoded in the cycle it is accepted; its results
//  (zero to four) land in a four-entry result buffer and leave one per cycle
//  while result_o.ready is high. A character that yields one result follows
//  its predecessor every cycle while result_o.ready stays high; one that yields
//  more results holds the input until its last buffered word leaves.
//  Reset: rst_ni clears the parse state and empties the buffer; no sweep.
//  Stalls: result_o.ready low holds the buffer; char_i waits while more than
//  the last buffered word is pending, or while that last word is held.
//
`include "uri_path_component_decoder_unit_defines.svh"

module uri_path_component_decoder_unit #(
  parameter int unsigned MAX_COMPONENTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  upd_stream_if.sink    char_i,
  upd_stream_if.source  result_o
);

  localparam int unsigned CW = (MAX_COMPONENTS > 2) ? $clog2(MAX_COMPONENTS) : 1;
  localparam logic [CW-1:0] TakeLimit = CW'(MAX_COMPONENTS - 1);

  // Parse state
  logic          at_start_q, at_start_d;
  logic          open_q, open_d;
  logic [1:0]    pend_q, pend_d;
  logic [7:0]    hex_q, hex_d;
  logic [CW-1:0] taken_q, taken_d;
  logic [11:0]   bytes_q, bytes_d;

  // Result buffer
  upd_pkg::result_word_t res_q [upd_pkg::MaxResults];
  upd_pkg::result_word_t res_d [upd_pkg::MaxResults];
  logic [2:0]    nres_d;
  logic [2:0]    rem_q;
  logic [1:0]    rd_q;

  logic [7:0]    ch;
  logic          last;
  logic          skip;
  logic          do_close;
  logic          in_fire;
  logic          out_fire;

  // Fold the component counter onto the 6-bit result fields.
  function automatic logic [5:0] to_idx(input logic [CW-1:0] t);
    logic [CW+5:0] ext;
    ext = {6'd0, t};
    return ext[5:0];
  endfunction

  function automatic upd_pkg::result_word_t mk_word(
    input upd_pkg::kind_e kind,
    input logic [7:0]     data,
    input logic [5:0]     idx,
    input logic [11:0]    len,
    input logic [5:0]     total
  );
    upd_pkg::result_word_t w;
    w.kind        = kind;
    w.data_byte   = data;
    w.comp_index  = idx;
    w.comp_length = len;
    w.comp_total  = total;
    w.run_last    = 1'b0;
    return w;
  endfunction

  assign ch   = char_i.payload.char_code;
  assign last = char_i.payload.last_char;

  // Take a new character once the buffer is empty or its final word leaves.
  assign char_i.ready   = (rem_q == 3'd0) || (rem_q == 3'd1 && result_o.ready);
  assign in_fire        = char_i.valid && char_i.ready;
  assign result_o.valid = (rem_q != 3'd0);
  assign result_o.payload = res_q[rd_q];
  assign out_fire       = result_o.valid && result_o.ready;

  // Single-pass decode of one character into up to four result words.
  always_comb begin
    at_start_d = at_start_q;
    open_d     = open_q;
    pend_d     = pend_q;
    hex_d      = hex_q;
    taken_d    = taken_q;
    bytes_d    = bytes_q;
    nres_d     = 3'd0;
    skip       = 1'b0;
    do_close   = 1'b0;
    for (int i = 0; i < upd_pkg::MaxResults; i++) begin
      res_d[i] = '0;
    end

    // Drop a single leading slash.
    if (at_start_q) begin
      at_start_d = 1'b0;
      skip       = (ch == upd_pkg::ChSlash);
    end

    if (!skip) begin
      // Open a component unless the limit is reached.
      if (!open_d && taken_d < TakeLimit) begin
        open_d  = 1'b1;
        bytes_d = '0;
        pend_d  = 2'd0;
        hex_d   = '0;
      end
      if (open_d && ch != upd_pkg::ChSlash) begin
        case (pend_d)
          2'd0: begin
            if (ch == upd_pkg::ChPercent) begin
              pend_d = 2'd1;
            end else begin
              res_d[nres_d[1:0]] = mk_word(upd_pkg::KindData, ch, to_idx(taken_d),
                                           12'd0, 6'd0);
              nres_d = nres_d + 3'd1;
              if (bytes_d != upd_pkg::LenMax) bytes_d = bytes_d + 12'd1;
            end
          end
          2'd1: begin
            hex_d  = ch;
            pend_d = 2'd2;
          end
          default: begin
            res_d[nres_d[1:0]] = mk_word(upd_pkg::KindData,
                                         {upd_pkg::hex_nibble(hex_d),
                                          upd_pkg::hex_nibble(ch)},
                                         to_idx(taken_d), 12'd0, 6'd0);
            nres_d = nres_d + 3'd1;
            if (bytes_d != upd_pkg::LenMax) bytes_d = bytes_d + 12'd1;
            pend_d = 2'd0;
            hex_d  = '0;
          end
        endcase
      end
    end

    // A slash or the last character closes the open component.
    do_close = open_d && ((!skip && ch == upd_pkg::ChSlash) || last);
    if (do_close) begin
      // Flush a cut-short percent sequence literally.
      if (pend_d != 2'd0) begin
        res_d[nres_d[1:0]] = mk_word(upd_pkg::KindData, upd_pkg::ChPercent,
                                     to_idx(taken_d), 12'd0, 6'd0);
        nres_d = nres_d + 3'd1;
        if (bytes_d != upd_pkg::LenMax) bytes_d = bytes_d + 12'd1;
      end
      if (pend_d == 2'd2) begin
        res_d[nres_d[1:0]] = mk_word(upd_pkg::KindData, hex_d,
                                     to_idx(taken_d), 12'd0, 6'd0);
        nres_d = nres_d + 3'd1;
        if (bytes_d != upd_pkg::LenMax) bytes_d = bytes_d + 12'd1;
      end
      pend_d = 2'd0;
      hex_d  = '0;
      res_d[nres_d[1:0]] = mk_word(upd_pkg::KindCompEnd, 8'd0, to_idx(taken_d),
                                   bytes_d, 6'd0);
      nres_d  = nres_d + 3'd1;
      taken_d = taken_d + CW'(1);
      bytes_d = '0;
      open_d  = 1'b0;
    end

    // Close the name and return to the start state.
    if (last) begin
      res_d[nres_d[1:0]] = mk_word(upd_pkg::KindNameEnd, 8'd0, 6'd0, 12'd0,
                                   to_idx(taken_d));
      nres_d     = nres_d + 3'd1;
      at_start_d = 1'b1;
      open_d     = 1'b0;
      pend_d     = 2'd0;
      hex_d      = '0;
      taken_d    = '0;
      bytes_d    = '0;
    end

    // Flag the final word of this character's run.
    if (nres_d != 3'd0) begin
      res_d[2'(nres_d - 3'd1)].run_last = 1'b1;
    end
  end

  // Advance the parse state on every accepted character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      open_q     <= 1'b0;
      pend_q     <= 2'd0;
      hex_q      <= '0;
      taken_q    <= '0;
      bytes_q    <= '0;
    end else if (in_fire) begin
      at_start_q <= at_start_d;
      open_q     <= open_d;
      pend_q     <= pend_d;
      hex_q      <= hex_d;
      taken_q    <= taken_d;
      bytes_q    <= bytes_d;
    end
  end

  // Load a fresh run on accept, else drain one word per handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      rd_q  <= 2'd0;
    end else if (in_fire) begin
      rem_q <= nres_d;
      rd_q  <= 2'd0;
    end else if (out_fire) begin
      rem_q <= rem_q - 3'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `UPD_ASSERT_ALWAYS(a_rem_bound, rem_q <= 3'd4, "result buffer count out of range")
  `UPD_ASSERT(a_run_last, result_o.valid |-> (result_o.payload.run_last == (rem_q == 3'd1)), "run_last does not mark the final buffered word")
  `UPD_ASSERT(a_no_overrun, in_fire |-> (rem_q <= 3'd1), "character accepted over pending results")
  `UPD_ASSERT(a_name_reset, (in_fire && last) |=> (at_start_q && !open_q && taken_q == '0), "parse state not cleared after name end")

endmodule

### verif/tb_uri_path_component_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// URI path component decoder testbench
// Streams URI names character by character into the decoder, predicts every
// data, component-end and name-end word in a local model of the parser, and
// compares each word leaving the block against the oldest prediction. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_uri_path_component_decoder_unit;

  localparam int unsigned MaxComps   = 64;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned NumItems   = 210;

  logic clk_i;
  logic rst_ni;

  upd_stream_if #(.word_t(upd_pkg::char_word_t))   char_if ();
  upd_stream_if #(.word_t(upd_pkg::result_word_t)) result_if ();

  uri_path_component_decoder_unit #(
    .MAX_COMPONENTS(MaxComps)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .result_o(result_if)
  );

  // --------------------------------------------------------------------------
  // Parser model: mirrors the decoder state and the words one character makes
  // --------------------------------------------------------------------------
  logic         at_start;
  logic         comp_open;
  logic [1:0]   pend_cnt;     // 0 none, 1 percent held, 2 percent and a char
  logic [7:0]   pend_char;
  int unsigned  comps_taken;
  logic [11:0]  comp_bytes;

  upd_pkg::result_word_t step_words [upd_pkg::MaxResults];
  int unsigned           step_count;
  upd_pkg::result_word_t expected_results [$];

  function automatic logic [3:0] digit_value(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return 4'(ch - "0");
    if (ch >= "a" && ch <= "f") return 4'(ch - "a" + 8'd10);
    if (ch >= "A" && ch <= "F") return 4'(ch - "A" + 8'd10);
    return 4'd0;
  endfunction

  function automatic void clear_parse();
    at_start    = 1'b1;
    comp_open   = 1'b0;
    pend_cnt    = 2'd0;
    pend_char   = 8'd0;
    comps_taken = 0;
    comp_bytes  = 12'd0;
  endfunction

  function automatic void push_word(upd_pkg::kind_e k, logic [7:0] data, logic [11:0] len,
                                    logic [5:0] total);
    upd_pkg::result_word_t w;
    w             = '0;
    w.kind        = k;
    w.data_byte   = data;
    // Name-end words carry index 0; data and component-end carry the index.
    w.comp_index  = (k == upd_pkg::KindNameEnd) ? 6'd0 : 6'(comps_taken);
    w.comp_length = len;
    w.comp_total  = total;
    step_words[step_count] = w;
    step_count++;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    push_word(upd_pkg::KindData, b, 12'd0, 6'd0);
    if (comp_bytes != upd_pkg::LenMax) comp_bytes++;  // saturate the length
  endfunction

  // Flush a dangling percent sequence literally, then close the component.
  function automatic void close_component();
    if (pend_cnt >= 2'd1) emit_byte(upd_pkg::ChPercent);
    if (pend_cnt == 2'd2) emit_byte(pend_char);
    pend_cnt  = 2'd0;
    pend_char = 8'd0;
    push_word(upd_pkg::KindCompEnd, 8'd0, comp_bytes, 6'd0);
    comps_taken++;
    comp_bytes = 12'd0;
    comp_open  = 1'b0;
  endfunction

  function automatic void feed_component(logic [7:0] c);
    if (pend_cnt == 2'd0) begin
      if (c == upd_pkg::ChPercent) pend_cnt = 2'd1;
      else emit_byte(c);
    end else if (pend_cnt == 2'd1) begin
      pend_char = c;
      pend_cnt  = 2'd2;
    end else begin
      emit_byte({digit_value(pend_char), digit_value(c)});
      pend_cnt  = 2'd0;
      pend_char = 8'd0;
    end
  endfunction

  // Predict the words for one accepted character and queue them.
  function automatic void decode_char(upd_pkg::char_word_t cw);
    bit skip;
    skip       = 1'b0;
    step_count = 0;
    if (at_start) begin
      at_start = 1'b0;
      if (cw.char_code == upd_pkg::ChSlash) skip = 1'b1;
    end
    if (!skip) begin
      if (!comp_open && comps_taken < MaxComps - 1) begin
        comp_open  = 1'b1;
        comp_bytes = 12'd0;
        pend_cnt   = 2'd0;
        pend_char  = 8'd0;
      end
      // Past the component limit comp_open stays low and the char is dropped.
      if (comp_open) begin
        if (cw.char_code == upd_pkg::ChSlash) close_component();
        else feed_component(cw.char_code);
      end
    end
    if (cw.last_char) begin
      if (comp_open) close_component();
      push_word(upd_pkg::KindNameEnd, 8'd0, 12'd0, 6'(comps_taken));
      clear_parse();
    end
    if (step_count > 0) step_words[step_count-1].run_last = 1'b1;
    for (int i = 0; i < step_count; i++) expected_results.push_back(step_words[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Bookkeeping shared by the driver, the ready generator and the monitor
  // --------------------------------------------------------------------------
  upd_pkg::char_word_t pending_chars [$];
  int unsigned issued_chars;
  int unsigned accepted_chars;
  int unsigned results_seen;
  int unsigned results_acked;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned char_gap;
  int unsigned ready_gap;
  bit          char_calm;
  bit          ready_calm;

  // Per-word random idle gap, with runs of back-to-back traffic.
  function automatic int unsigned pick_gap(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    if (calm) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Character driver: present the next queued word after its idle gap, hold
  // it until the handshake, change inputs only on the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // The word on the bus was taken at the last rising edge: draw the gap.
      if (char_if.valid && accepted_chars == issued_chars) char_gap = pick_gap(char_calm);
      if (!char_if.valid || accepted_chars == issued_chars) begin
        if (char_gap > 0) begin
          char_gap--;
          char_if.valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          char_if.payload <= pending_chars.pop_front();
          char_if.valid   <= 1'b1;
          issued_chars++;
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: after each taken word, drop ready for a random stretch.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_if.ready && results_seen != results_acked) begin
        results_acked = results_seen;
        ready_gap     = pick_gap(ready_calm);
      end
      if (ready_gap > 0) begin
        ready_gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. Predict first so a
  // word that leaves in the same cycle still finds its expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    upd_pkg::result_word_t got;
    upd_pkg::result_word_t want;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        if (char_if.valid && char_if.ready) begin
          accepted_chars++;
          decode_char(char_if.payload);
        end
        if (result_if.valid && result_if.ready) begin
          results_seen++;
          got = result_if.payload;
          if (expected_results.size() == 0) begin
            flag_error($sformatf({"word %0d unexpected: kind=%0d data=%02h idx=%0d ",
                                  "len=%0d tot=%0d last=%0b"},
                                 results_seen, got.kind, got.data_byte, got.comp_index,
                                 got.comp_length, got.comp_total, got.run_last));
          end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.comp_index !== want.comp_index ||
                got.comp_length !== want.comp_length ||
                got.comp_total !== want.comp_total || got.run_last !== want.run_last) begin
              flag_error($sformatf({"word %0d mismatch: exp kind=%0d data=%02h idx=%0d ",
                                    "len=%0d tot=%0d last=%0b, got kind=%0d data=%02h ",
                                    "idx=%0d len=%0d tot=%0d last=%0b"},
                                   results_seen, want.kind, want.data_byte, want.comp_index,
                                   want.comp_length, want.comp_total, want.run_last,
                                   got.kind, got.data_byte, got.comp_index,
                                   got.comp_length, got.comp_total, got.run_last));
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_char(logic [7:0] c, bit last);
    upd_pkg::char_word_t w;
    w.char_code = c;
    w.last_char = last;
    pending_chars.push_back(w);
  endtask

  task automatic add_text(string s, bit ends_name);
    for (int i = 0; i < s.len(); i++) add_char(s[i], ends_name && (i == s.len() - 1));
  endtask

  // One name: mostly well-formed paths with escapes (some cut short by the
  // end of their component), sometimes raw byte noise.
  task automatic add_random_name();
    logic [7:0] text [$];
    string      hex_digits;
    int         n_comps;
    int         len;
    int         pick;
    hex_digits = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, 10);
      repeat (len) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 1) == 1) text.push_back(upd_pkg::ChSlash);
      n_comps = $urandom_range(1, 5);
      for (int k = 0; k < n_comps; k++) begin
        if (k > 0) text.push_back(upd_pkg::ChSlash);
        len = $urandom_range(0, 6);
        for (int j = 0; j < len; j++) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            text.push_back(upd_pkg::ChPercent);
            if (pick >= 1) text.push_back(hex_digits[$urandom_range(0, 21)]);
            if (pick >= 2) begin
              // A hex digit or a random byte; a non-hex byte reads as zero.
              if (pick == 3) text.push_back(8'($urandom_range(1, 255)));
              else text.push_back(hex_digits[$urandom_range(0, 21)]);
            end
          end else if (pick < 7) begin
            text.push_back(8'($urandom_range(8'h20, 8'h7E)));
          end else begin
            text.push_back(8'($urandom_range(1, 255)));
          end
        end
      end
      if ($urandom_range(0, 3) == 0) text.push_back(upd_pkg::ChSlash);
    end
    if (text.size() == 0) text.push_back("x");
    for (int i = 0; i < text.size(); i++) add_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    int unsigned name_no;

    char_if.valid   = 1'b0;
    char_if.payload = '0;
    result_if.ready = 1'b0;
    issued_chars    = 0;
    accepted_chars  = 0;
    results_seen    = 0;
    results_acked   = 0;
    error_count     = 0;
    cycle_count     = 0;
    char_gap        = 0;
    ready_gap       = 0;
    char_calm       = 1'b0;
    ready_calm      = 1'b1;
    clear_parse();

    // Directed: a lone slash, a skipped slash before an empty component,
    // escapes in both cases with a trailing slash, a non-hex escape cut by
    // the name end, a lone percent, extreme byte values.
    add_text("/", 1'b1);
    add_text("//", 1'b1);
    add_text("/%4a%F0x/", 1'b1);
    add_text("b//%z", 1'b1);
    add_text("%", 1'b1);
    add_char(8'h01, 1'b0);
    add_char(8'hFF, 1'b0);
    add_text("%4", 1'b1);

    // Random names until the character budget is spent.
    name_no = 0;
    while (pending_chars.size() < NumItems) begin
      name_no++;
      if (name_no == 4) begin
        // Run past the component limit; the tail is dropped but still ends.
        for (int k = 0; k < 66; k++) begin
          if ($urandom_range(0, 2) != 0) add_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
          add_char(upd_pkg::ChSlash, 1'b0);
        end
        add_text("%41q", 1'b1);
      end else begin
        add_random_name();
      end
    end

    // Drain: all characters taken, all words seen, then watch for strays.
    while (pending_chars.size() != 0 || accepted_chars != issued_chars) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/upd_pkg.sv
hw/rtl/upd_stream_if.sv
hw/rtl/uri_path_component_decoder_unit.sv
verif/tb_uri_path_component_decoder_unit.sv
